// ===== rtl/awb_pkg.sv =====
// ----------------------------------------------------------------------------
// awb_pkg
// shared types and constants for the white-balance channel gain calculator
// ----------------------------------------------------------------------------
package awb_pkg;

  localparam int unsigned VAL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 8;

  // pipelined restoring divider: numerator bits, steps per stage, stages
  localparam int unsigned DIV_NUM_W  = 28;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = DIV_NUM_W / DIV_STEPS;
  localparam int unsigned PIPE_DEPTH = 2 * DIV_STAGES;

  localparam logic [VAL_W-1:0] RATIO_ONE  = 16'd512;
  localparam logic [VAL_W-1:0] UNITY_GAIN = 16'h0100;
  // 0x100 * 512
  localparam logic [DIV_NUM_W-1:0] GREEN_NUM = 28'h002_0000;

  localparam logic [CFG_IDX_W-1:0] REG_TYPICAL_RG = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPICAL_BG = 8'd1;

  typedef struct packed {
    logic [VAL_W-1:0] measured_rg;
    logic [VAL_W-1:0] measured_bg;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] red_gain;
    logic [VAL_W-1:0] green_gain;
    logic [VAL_W-1:0] blue_gain;
    logic             status;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] rr;
    logic [VAL_W-1:0] br;
    logic             fail;
  } ratio_t;

endpackage

// ===== rtl/awb_div_pipe.sv =====
// ----------------------------------------------------------------------------
// awb_div_pipe
// pipelined restoring divider, four quotient bits per stage, low 16 bits kept
// ----------------------------------------------------------------------------
module awb_div_pipe (
  input  logic                             clk,
  input  logic                             en,
  input  logic [awb_pkg::DIV_NUM_W-1:0]    num_i,
  input  logic [awb_pkg::VAL_W-1:0]        den_i,
  output logic [awb_pkg::VAL_W-1:0]        quo_o
);

  logic [awb_pkg::DIV_NUM_W-1:0] num_r [awb_pkg::DIV_STAGES];
  logic [awb_pkg::VAL_W-1:0]     den_r [awb_pkg::DIV_STAGES];
  logic [awb_pkg::VAL_W-1:0]     rem_r [awb_pkg::DIV_STAGES];
  logic [awb_pkg::VAL_W-1:0]     quo_r [awb_pkg::DIV_STAGES];

  for (genvar s = 0; s < int'(awb_pkg::DIV_STAGES); s++) begin : g_stage
    logic [awb_pkg::DIV_NUM_W-1:0] num_in;
    logic [awb_pkg::VAL_W-1:0]     den_in;
    logic [awb_pkg::VAL_W-1:0]     rem_in;
    logic [awb_pkg::VAL_W-1:0]     quo_in;
    logic [awb_pkg::DIV_NUM_W-1:0] num_nxt;
    logic [awb_pkg::VAL_W-1:0]     rem_nxt;
    logic [awb_pkg::VAL_W-1:0]     quo_nxt;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      logic [awb_pkg::VAL_W:0] trial;
      num_nxt = num_in;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int j = 0; j < int'(awb_pkg::DIV_STEPS); j++) begin
        trial   = {rem_nxt, num_nxt[awb_pkg::DIV_NUM_W-1]};
        num_nxt = {num_nxt[awb_pkg::DIV_NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = awb_pkg::VAL_W'(trial - {1'b0, den_in});
          quo_nxt = {quo_nxt[awb_pkg::VAL_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[awb_pkg::VAL_W-1:0];
          quo_nxt = {quo_nxt[awb_pkg::VAL_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= num_nxt;
        den_r[s] <= den_in;
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[awb_pkg::DIV_STAGES-1];

endmodule

// ===== rtl/awb_gain_sel.sv =====
// ----------------------------------------------------------------------------
// awb_gain_sel
// unity channel plus two scaled gains from the ratio quotients, zeros on fail
// ----------------------------------------------------------------------------
module awb_gain_sel (
  input  awb_pkg::ratio_t            rat_i,
  input  logic [awb_pkg::VAL_W-1:0]  gr_i,
  input  logic [awb_pkg::VAL_W-1:0]  gb_i,
  input  logic [awb_pkg::VAL_W-1:0]  rxb_i,
  input  logic [awb_pkg::VAL_W-1:0]  bxr_i,
  output awb_pkg::out_t              res_o
);

  logic r_hi;
  logic b_hi;

  assign r_hi = (rat_i.rr >= awb_pkg::RATIO_ONE);
  assign b_hi = (rat_i.br >= awb_pkg::RATIO_ONE);

  always_comb begin
    res_o.status = 1'b0;
    if (rat_i.fail) begin
      res_o = '0;
      res_o.status = 1'b1;
    end else if (r_hi && b_hi) begin
      // 0x100 * ratio / 512
      res_o.red_gain   = {1'b0, rat_i.rr[awb_pkg::VAL_W-1:1]};
      res_o.green_gain = awb_pkg::UNITY_GAIN;
      res_o.blue_gain  = {1'b0, rat_i.br[awb_pkg::VAL_W-1:1]};
    end else if (r_hi) begin
      res_o.red_gain   = rxb_i;
      res_o.green_gain = gb_i;
      res_o.blue_gain  = awb_pkg::UNITY_GAIN;
    end else if (b_hi || (gr_i >= gb_i)) begin
      res_o.red_gain   = awb_pkg::UNITY_GAIN;
      res_o.green_gain = gr_i;
      res_o.blue_gain  = bxr_i;
    end else begin
      res_o.red_gain   = rxb_i;
      res_o.green_gain = gb_i;
      res_o.blue_gain  = awb_pkg::UNITY_GAIN;
    end
  end

endmodule

// ===== rtl/awb_channel_gain_calc.sv =====
// path from request accepted to result valid: two 7-stage divider pipelines
// plus the output register
// throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output
// reset: synchronous active-low rst_n clears valid bits and both typical ratios
// ----------------------------------------------------------------------------
// awb_channel_gain_calc
// white-balance channel gains from measured and golden r/g, b/g ratios
// ----------------------------------------------------------------------------
module awb_channel_gain_calc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  awb_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output awb_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [awb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awb_pkg::VAL_W-1:0]        cfg_data
);

  localparam int unsigned NS = awb_pkg::DIV_STAGES;
  localparam int unsigned ND = awb_pkg::PIPE_DEPTH;

  logic [awb_pkg::VAL_W-1:0] typical_rg_r;
  logic [awb_pkg::VAL_W-1:0] typical_bg_r;
  logic [ND-1:0]             vld_r;
  logic [NS-1:0]             fail_r;
  awb_pkg::ratio_t           rat_r [NS];
  awb_pkg::ratio_t           rat_nxt;
  logic                      out_valid_r;
  awb_pkg::out_t             out_data_r;
  awb_pkg::out_t             res_nxt;

  logic                      en;
  logic                      in_fire;
  logic                      zero_in;
  logic [awb_pkg::VAL_W-1:0] rr_q;
  logic [awb_pkg::VAL_W-1:0] br_q;
  logic [awb_pkg::VAL_W-1:0] gr_q;
  logic [awb_pkg::VAL_W-1:0] gb_q;
  logic [awb_pkg::VAL_W-1:0] rxb_q;
  logic [awb_pkg::VAL_W-1:0] bxr_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      typical_rg_r <= '0;
      typical_bg_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == awb_pkg::REG_TYPICAL_RG) begin
        typical_rg_r <= cfg_data;
      end
      if (cfg_index == awb_pkg::REG_TYPICAL_BG) begin
        typical_bg_r <= cfg_data;
      end
    end
  end

  // whole pipeline advances whenever the output slot is free or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_fire  = in_valid && in_ready;

  assign zero_in = (in_data.measured_rg == '0) || (in_data.measured_bg == '0) ||
                   (typical_rg_r == '0) || (typical_bg_r == '0);

  // first pass: 512 * typical / measured
  awb_div_pipe u_div_rr (
    .clk   (clk),
    .en    (en),
    .num_i ({3'b000, typical_rg_r, 9'd0}),
    .den_i (in_data.measured_rg),
    .quo_o (rr_q)
  );

  awb_div_pipe u_div_br (
    .clk   (clk),
    .en    (en),
    .num_i ({3'b000, typical_bg_r, 9'd0}),
    .den_i (in_data.measured_bg),
    .quo_o (br_q)
  );

  always_comb begin
    rat_nxt.rr   = rr_q;
    rat_nxt.br   = br_q;
    rat_nxt.fail = fail_r[NS-1] || (rr_q == '0) || (br_q == '0);
  end

  // second pass: all four candidate quotients run side by side
  awb_div_pipe u_div_gr (
    .clk   (clk),
    .en    (en),
    .num_i (awb_pkg::GREEN_NUM),
    .den_i (rr_q),
    .quo_o (gr_q)
  );

  awb_div_pipe u_div_gb (
    .clk   (clk),
    .en    (en),
    .num_i (awb_pkg::GREEN_NUM),
    .den_i (br_q),
    .quo_o (gb_q)
  );

  awb_div_pipe u_div_rxb (
    .clk   (clk),
    .en    (en),
    .num_i ({4'b0000, rr_q, 8'd0}),
    .den_i (br_q),
    .quo_o (rxb_q)
  );

  awb_div_pipe u_div_bxr (
    .clk   (clk),
    .en    (en),
    .num_i ({4'b0000, br_q, 8'd0}),
    .den_i (rr_q),
    .quo_o (bxr_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[ND-2:0], in_fire};
      out_valid_r <= vld_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fail_r   <= {fail_r[NS-2:0], zero_in};
      rat_r[0] <= rat_nxt;
      for (int k = 1; k < int'(NS); k++) begin
        rat_r[k] <= rat_r[k-1];
      end
      out_data_r <= res_nxt;
    end
  end

  awb_gain_sel u_sel (
    .rat_i (rat_r[NS-1]),
    .gr_i  (gr_q),
    .gb_i  (gb_q),
    .rxb_i (rxb_q),
    .bxr_i (bxr_q),
    .res_o (res_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_awb_channel_gain_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_awb_channel_gain_calc
// self-checking bench for the white-balance gain calculator: gains are
// predicted per request from the golden ratios last written, and every result
// is compared in order while both handshakes idle and stall at random
// ----------------------------------------------------------------------------
module tb_awb_channel_gain_calc;

  typedef logic [awb_pkg::VAL_W-1:0]     val_t;
  typedef logic [awb_pkg::CFG_IDX_W-1:0] idx_t;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam idx_t REG_UNMAPPED = '1;
  localparam logic [31:0] ONE_W   = 32'(awb_pkg::RATIO_ONE);
  localparam logic [31:0] UNITY_W = 32'(awb_pkg::UNITY_GAIN);
  localparam logic [31:0] GREEN_W = UNITY_W * ONE_W;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  awb_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  awb_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  idx_t cfg_index = '0;
  val_t cfg_data = '0;

  // golden ratios as the block should hold them
  val_t golden_rg = '0;
  val_t golden_bg = '0;

  awb_pkg::in_t pending_reqs[$];
  awb_pkg::out_t gains_due[$];

  int unsigned errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_checked = 0;
  int unsigned n_flagged = 0;
  int unsigned n_writes = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_left = 0;
  int unsigned block_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e rx_mode = RX_OPEN;

  awb_channel_gain_calc dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic val_t quot16(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] q;
    q = num / den;
    return q[awb_pkg::VAL_W-1:0];
  endfunction

  function automatic awb_pkg::out_t predict_gains(input awb_pkg::in_t req, input val_t typ_rg,
                                                  input val_t typ_bg);
    awb_pkg::out_t res;
    val_t r_ratio;
    val_t b_ratio;
    val_t green_r;
    val_t green_b;
    res = '0;
    res.status = 1'b1;
    if (req.measured_rg == '0 || req.measured_bg == '0 || typ_rg == '0 || typ_bg == '0)
      return res;
    r_ratio = quot16(ONE_W * typ_rg, 32'(req.measured_rg));
    b_ratio = quot16(ONE_W * typ_bg, 32'(req.measured_bg));
    if (r_ratio == '0 || b_ratio == '0)
      return res;
    res.status = 1'b0;
    if (r_ratio >= awb_pkg::RATIO_ONE && b_ratio >= awb_pkg::RATIO_ONE) begin
      res.red_gain   = quot16(UNITY_W * r_ratio, ONE_W);
      res.green_gain = awb_pkg::UNITY_GAIN;
      res.blue_gain  = quot16(UNITY_W * b_ratio, ONE_W);
    end else if (r_ratio >= awb_pkg::RATIO_ONE) begin
      res.red_gain   = quot16(UNITY_W * r_ratio, 32'(b_ratio));
      res.green_gain = quot16(GREEN_W, 32'(b_ratio));
      res.blue_gain  = awb_pkg::UNITY_GAIN;
    end else if (b_ratio >= awb_pkg::RATIO_ONE) begin
      res.red_gain   = awb_pkg::UNITY_GAIN;
      res.green_gain = quot16(GREEN_W, 32'(r_ratio));
      res.blue_gain  = quot16(UNITY_W * b_ratio, 32'(r_ratio));
    end else begin
      // both below one: the larger truncated green candidate decides
      green_r = quot16(GREEN_W, 32'(r_ratio));
      green_b = quot16(GREEN_W, 32'(b_ratio));
      if (green_r >= green_b) begin
        res.red_gain   = awb_pkg::UNITY_GAIN;
        res.green_gain = green_r;
        res.blue_gain  = quot16(UNITY_W * b_ratio, 32'(r_ratio));
      end else begin
        res.red_gain   = quot16(UNITY_W * r_ratio, 32'(b_ratio));
        res.green_gain = green_b;
        res.blue_gain  = awb_pkg::UNITY_GAIN;
      end
    end
    return res;
  endfunction

  function automatic val_t pick_measure(input val_t typ);
    val_t m;
    int unsigned spread;
    spread = typ / 4 + 1;
    case ($urandom_range(0, 15))
      0: m = '0;
      1, 2: m = val_t'($urandom_range(1, 16));
      3: m = val_t'($urandom_range(65520, 65535));
      4, 5, 6, 7, 8: m = val_t'(32'(typ) + $urandom_range(0, 2 * spread) - spread);
      default: m = val_t'($urandom);
    endcase
    return m;
  endfunction

  function automatic val_t pick_typical();
    val_t t;
    case ($urandom_range(0, 4))
      0: t = val_t'($urandom_range(256, 1024));
      1: t = val_t'($urandom_range(1, 255));
      2: begin
        case ($urandom_range(0, 3))
          0: t = '0;
          1: t = 16'd1;
          2: t = '1;
          default: t = awb_pkg::RATIO_ONE;
        endcase
      end
      default: t = val_t'($urandom);
    endcase
    return t;
  endfunction

  task automatic write_reg(input idx_t idx, input val_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    if (idx == awb_pkg::REG_TYPICAL_RG)
      golden_rg = val;
    else if (idx == awb_pkg::REG_TYPICAL_BG)
      golden_bg = val;
  endtask

  task automatic queue_request(input val_t rg, input val_t bg);
    awb_pkg::in_t req;
    req.measured_rg = rg;
    req.measured_bg = bg;
    pending_reqs = {pending_reqs, req};
  endtask

  // hold the sender until every request has come back
  task automatic drain();
    while (pending_reqs.size() != 0 || gains_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned chunk;
    random_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // golden ratios still unset after reset
    queue_request(16'd1, 16'd1);
    queue_request(16'hffff, 16'hffff);
    queue_request(16'd0, 16'd0);
    drain();
    write_reg(awb_pkg::REG_TYPICAL_RG, awb_pkg::RATIO_ONE);
    queue_request(16'd512, 16'd512);
    drain();

    write_reg(awb_pkg::REG_TYPICAL_BG, awb_pkg::RATIO_ONE);
    queue_request(16'd512, 16'd512);
    queue_request(16'd0, 16'd512);
    queue_request(16'd512, 16'd0);
    queue_request(16'd256, 16'd1024);
    queue_request(16'd1024, 16'd256);
    queue_request(16'd1024, 16'd655);
    queue_request(16'd655, 16'd1024);
    queue_request(16'hffff, 16'hffff);
    queue_request(16'd1, 16'd1);
    drain();

    // tiny golden ratios: ratios truncate to zero, green candidates wrap
    write_reg(awb_pkg::REG_TYPICAL_RG, 16'd1);
    write_reg(awb_pkg::REG_TYPICAL_BG, 16'd1);
    queue_request(16'd1, 16'd1);
    queue_request(16'd513, 16'd1);
    queue_request(16'd1, 16'hffff);
    queue_request(16'd512, 16'd171);
    queue_request(16'hffff, 16'hffff);
    drain();

    // ratio of exactly 65536 wraps to zero, full-scale golden ratio wraps
    write_reg(awb_pkg::REG_TYPICAL_RG, 16'd128);
    write_reg(awb_pkg::REG_TYPICAL_BG, 16'hffff);
    queue_request(16'd1, 16'd1);
    queue_request(16'd2, 16'd1);
    queue_request(16'd3, 16'hffff);
    drain();

    // write to an unmapped index must leave both ratios alone
    write_reg(REG_UNMAPPED, 16'd0);
    queue_request(16'd512, 16'd512);
    drain();

    chunk = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0)
        write_reg(awb_pkg::REG_TYPICAL_RG, pick_typical());
      if ($urandom_range(0, 3) != 0)
        write_reg(awb_pkg::REG_TYPICAL_BG, pick_typical());
      if ($urandom_range(0, 7) == 0)
        write_reg(idx_t'($urandom_range(awb_pkg::REG_TYPICAL_BG + 1, REG_UNMAPPED)),
                  val_t'($urandom));
      repeat ($urandom_range(60, 140)) begin
        queue_request(pick_measure(golden_rg), pick_measure(golden_bg));
        random_sent++;
      end
      drain();
      chunk++;
    end

    repeat (awb_pkg::PIPE_DEPTH + 16) @(posedge clk);
    $display("tb: %0d requests in %0d random batches, %0d register writes", n_requests, chunk,
             n_writes);
    $display("tb: %0d results checked, %0d of them flagged as failed", n_checked, n_flagged);
    if (errors == 0 && gains_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // request driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        gains_due = {gains_due, predict_gains(in_data, golden_rg, golden_bg)};
        void'(pending_reqs.pop_front());
        n_requests++;
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs[0];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: stall pattern switches between modes every so often
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
        default: begin
          if (block_left > 0) begin
            block_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            block_left = $urandom_range(5, 30);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gains_due.size() == 0) begin
        $error("result with no request outstanding: %h", out_data);
        errors++;
      end else begin
        awb_pkg::out_t exp_res;
        exp_res = gains_due.pop_front();
        n_checked++;
        if (exp_res.status)
          n_flagged++;
        if (out_data.red_gain !== exp_res.red_gain) begin
          $error("red_gain: expected %h, got %h", exp_res.red_gain, out_data.red_gain);
          errors++;
        end
        if (out_data.green_gain !== exp_res.green_gain) begin
          $error("green_gain: expected %h, got %h", exp_res.green_gain, out_data.green_gain);
          errors++;
        end
        if (out_data.blue_gain !== exp_res.blue_gain) begin
          $error("blue_gain: expected %h, got %h", exp_res.blue_gain, out_data.blue_gain);
          errors++;
        end
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %h, got %h", exp_res.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no request, result or register write moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/awb_pkg.sv
rtl/awb_div_pipe.sv
rtl/awb_gain_sel.sv
rtl/awb_channel_gain_calc.sv
dv/tb_awb_channel_gain_calc.sv
